// ===== design/ppisl_pkg.sv =====
package ppisl_pkg;

	// sound register file size, 2 to 16
	localparam int SOUND_REG_COUNT = 16;
	localparam int SND_ADDR_W      = $clog2(SOUND_REG_COUNT);
	localparam int SND_IDX_W       = 4;

	localparam logic [7:0] CTRL_RESET = 8'h82;
	localparam logic [3:0] DIP_RESET  = 4'hF;
	localparam logic       FUNC_READ  = 1'b0;
	localparam logic       FUNC_WRITE = 1'b1;

	typedef enum logic [1:0] {
		SEL_PORT_A = 2'd0,
		SEL_PORT_B = 2'd1,
		SEL_PORT_C = 2'd2,
		SEL_CTRL   = 2'd3
	} sel_t;

	// action coded in port c bits 7-6
	typedef enum logic [1:0] {
		SND_NONE  = 2'd0,
		SND_READ  = 2'd1,
		SND_WRITE = 2'd2,
		SND_LATCH = 2'd3
	} snd_mode_t;

	typedef struct packed {
		logic       func;
		sel_t       sel;
		logic [7:0] wdata;
		logic       tape;
		logic       vsync;
	} access_t;

endpackage

// ===== design/parallel_io_with_sound_register_latch.sv =====
// Mode-0 parallel port with a sound chip register latch. Each input word is one bus
// access (read or write of port A, port B, port C or the control register) and
// produces exactly one output word: the byte read (zero for a write) together with
// the port C lines after the access (motor, led, keyboard row). An access has an
// accept cycle, reading the sound register file (a synchronous ram) at the current
// index, and an execute cycle, applying the access and loading the result word;
// s_tready is low in the execute cycle, so no new word is taken until the current
// one has executed. A finished word sits in the output register, and the next access
// is accepted while it waits; only the execute cycle stalls on a full output register.
// Port C and control writes act on the top two bits of the new port C value: 3 latches
// port A as the sound index, 2 writes port A into the indexed register, 1 makes port A
// reads return that register. The sound registers read as zero after reset through one
// valid flag per entry, so no clearing pass is needed. The user must write the dip
// switch nibble with dip_switches_we only while the block is idle; it is not enforced.
module parallel_io_with_sound_register_latch
	import ppisl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// dip switch register
	input  logic        dip_switches_we,
	input  logic [3:0]  dip_switches,
	// access words in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // write_data[7:0], tape_in[8], vsync[9], zero pad
	input  logic [2:0]  s_tuser,   // func[0], reg_select[2:1]
	// result words out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data[7:0], tape_motor_on[8], tape_led_on[9],
	                               // keyboard_row[13:10], zero pad
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	localparam int IDX_CMP_W = SND_IDX_W + 1;

	state_t                 state_q;
	access_t                acc_s1;
	logic [3:0]             dip_q;
	logic [7:0]             latch_a_q;
	logic [7:0]             latch_c_q;
	logic [7:0]             ctrl_q;
	logic [SND_IDX_W-1:0]   snd_idx_q;
	logic [SOUND_REG_COUNT-1:0] snd_valid_q;
	logic                   m_tvalid_q;
	logic [15:0]            m_tdata_q;

	logic                   in_fire;
	logic                   exec_fire;
	logic [SND_ADDR_W-1:0]  snd_addr;
	logic                   idx_ok;
	logic [7:0]             ram_rdata;
	logic                   ram_we;
	logic [7:0]             snd_value;

	logic [7:0]             nxt_a;
	logic [7:0]             nxt_c;
	logic [7:0]             nxt_ctrl;
	logic [SND_IDX_W-1:0]   nxt_idx;
	logic                   c_wr;
	logic [7:0]             c_val;
	logic [7:0]             bit_mask;
	logic [7:0]             rd;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	// execute only when the output register is free or being drained
	assign exec_fire = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// index beyond the file is ignored for writes and read-mode reads
	assign idx_ok   = ({1'b0, snd_idx_q} < IDX_CMP_W'(SOUND_REG_COUNT));
	assign snd_addr = snd_idx_q[SND_ADDR_W-1:0];
	// entries never written since reset read as zero
	assign snd_value = snd_valid_q[snd_addr] ? ram_rdata : 8'h00;

	// sound register file, read every cycle at the current index
	ppisl_ram #(
		.WIDTH (8),
		.DEPTH (SOUND_REG_COUNT)
	) u_snd_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (snd_addr),
		.wdata (latch_a_q),
		.raddr (snd_addr),
		.rdata (ram_rdata)
	);

	// access execution
	always_comb begin
		nxt_a    = latch_a_q;
		nxt_c    = latch_c_q;
		nxt_ctrl = ctrl_q;
		nxt_idx  = snd_idx_q;
		c_wr     = 1'b0;
		c_val    = 8'h00;
		ram_we   = 1'b0;
		rd       = 8'h00;
		bit_mask = 8'h01 << acc_s1.wdata[3:1];

		if (acc_s1.func == FUNC_WRITE) begin
			unique case (acc_s1.sel)
				SEL_PORT_A: nxt_a = acc_s1.wdata;
				SEL_PORT_B: ;
				SEL_PORT_C: begin
					c_wr  = 1'b1;
					c_val = acc_s1.wdata;
				end
				SEL_CTRL: begin
					c_wr = 1'b1;
					if (acc_s1.wdata[7]) begin
						// mode set: store word, clear ports a and c
						nxt_ctrl = acc_s1.wdata;
						nxt_a    = 8'h00;
						c_val    = 8'h00;
					end else if (acc_s1.wdata[0]) begin
						// single bit set of port c
						c_val = latch_c_q | bit_mask;
					end else begin
						c_val = latch_c_q & ~bit_mask;
					end
				end
				default: ;
			endcase
		end else begin
			unique case (acc_s1.sel)
				SEL_PORT_A: begin
					if ((snd_mode_t'(latch_c_q[7:6]) == SND_READ) && idx_ok) begin
						rd = snd_value;
					end else begin
						rd = latch_a_q;
					end
				end
				SEL_PORT_B: rd = {acc_s1.tape, 2'b11, acc_s1.vsync, dip_q};
				SEL_PORT_C: rd = latch_c_q;
				SEL_CTRL:   rd = ctrl_q;
				default:    rd = 8'h00;
			endcase
		end

		// every port c change acts on its top two bits
		if (c_wr) begin
			nxt_c = c_val;
			case (snd_mode_t'(c_val[7:6]))
				SND_WRITE: ram_we  = exec_fire && idx_ok;
				SND_LATCH: nxt_idx = latch_a_q[SND_IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			acc_s1.func  <= s_tuser[0];
			acc_s1.sel   <= sel_t'(s_tuser[2:1]);
			acc_s1.wdata <= s_tdata[7:0];
			acc_s1.tape  <= s_tdata[8];
			acc_s1.vsync <= s_tdata[9];
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (exec_fire) begin
			m_tdata_q <= {2'b00, nxt_c[3:0], nxt_c[5], nxt_c[4], rd};
		end
	end

	// control and port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dip_q       <= DIP_RESET;
			latch_a_q   <= 8'h00;
			latch_c_q   <= 8'h00;
			ctrl_q      <= CTRL_RESET;
			snd_idx_q   <= '0;
			snd_valid_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (dip_switches_we) begin
				dip_q <= dip_switches;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (exec_fire) begin
				latch_a_q  <= nxt_a;
				latch_c_q  <= nxt_c;
				ctrl_q     <= nxt_ctrl;
				snd_idx_q  <= nxt_idx;
				m_tvalid_q <= 1'b1;
				if (ram_we) begin
					snd_valid_q[snd_addr] <= 1'b1;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// an accepted word blocks the next one for its execute cycle
	a_accept_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_tready)
		else $error("word accepted during execute cycle");

	// a new result word only follows an execute cycle
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_EXEC))
		else $error("result word without execute");

	// a sound write marks its entry as holding data
	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> snd_valid_q[$past(snd_addr)])
		else $error("sound entry not marked valid after write");

	// port c only moves on an executed access
	a_port_c_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!exec_fire |=> $stable(latch_c_q))
		else $error("port c changed outside execute");

endmodule

// ===== design/ppisl_ram.sv =====
module ppisl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
